// ===== design/tcsw_pkg.sv =====
package tcsw_pkg;

  // Screen geometry (maximum size of the cell store)
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = ROW_W + COL_W;

  // Cell encoding and special characters
  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  TEXT_ATTR  = 8'h07;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [7:0]  CH_NUL     = 8'd0;

  // Reset values of the configuration registers
  localparam logic [7:0] RESET_COLS = 8'd80;
  localparam logic [5:0] RESET_ROWS = 6'd25;

  // Request types
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_type_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_ROW_COUNT    = 2'd1
  } cfg_index_t;

  // Payload of one request
  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } in_req_t;

  // Payload of one result
  typedef struct packed {
    logic [15:0] cell_data;
    logic [5:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_res_t;

endpackage

// ===== design/tcsw_if.sv =====
// Request channel: valid/ready handshake with a request payload.
interface tcsw_in_if import tcsw_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Result channel: valid/ready handshake with a result payload.
interface tcsw_out_if import tcsw_pkg::*; ();
  logic     valid;
  logic     ready;
  out_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/text_console_scroll_writer_unit.sv =====
// Steps: a read or a character write without scroll goes from accept to the handoff state
// and then to the result register. A write that scrolls first copies rows 1 to
// row_count - 1 up by one row (skipped when row_count is 1), then fills the last row with
// blank cells and then places the character; the cell memory moves one cell per cycle through its write port.
// The block takes no new request until the result of the last one has been loaded.
// Reset: synchronous, active low; afterwards the memory is cleared to blank cells,
// during which no request is taken (configuration writes are taken).
module text_console_scroll_writer_unit import tcsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tcsw_in_if.sink     in_req,
  tcsw_out_if.source  out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCROLL = 6'b000100,
    S_BLANK  = 6'b001000,
    S_APPLY  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]        column_count_r, column_count_nxt;
  logic [5:0]        row_count_r, row_count_nxt;
  logic [5:0]        cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [ROW_W-1:0]  scr_row_r, scr_row_nxt;
  logic [COL_W-1:0]  scr_col_r, scr_col_nxt;
  logic              cp_wr_r, cp_wr_nxt;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic              is_read_r, is_read_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;

  // Cell memory
  logic [15:0]       mem [2**ADDR_W];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       rd_data_r;

  logic        in_ready;
  logic        in_acc;
  logic        scroll_need;
  logic        col_last;
  logic        row_last;
  logic [4:0]  blank_row;
  logic [7:0]  app_ch;
  logic [7:0]  col_inc;
  logic        app_we;
  logic [5:0]  app_row;
  logic [6:0]  app_col;
  logic [7:0]  new_cols;
  logic [5:0]  new_rows;

  assign in_ready     = (state_r == S_IDLE);
  assign in_req.ready = in_ready;
  assign in_acc       = in_req.valid && in_ready;

  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_data_r;

  assign scroll_need = (cursor_row_r == row_count_r);
  assign col_last    = (({1'b0, scr_col_r} + 8'd1) == column_count_r);
  assign row_last    = (({1'b0, scr_row_r} + 6'd1) == row_count_r);
  assign blank_row   = 5'(row_count_r - 6'd1);

  // Character placement at the cursor: newline, carriage return or a stored glyph.
  always_comb begin
    app_ch  = (state_r == S_APPLY) ? ch_r : in_req.payload.char_code;
    col_inc = {1'b0, cursor_col_r} + 8'd1;
    app_we  = 1'b0;
    app_row = cursor_row_r;
    app_col = cursor_col_r;
    if (app_ch == CH_NEWLINE) begin
      app_col = '0;
      app_row = cursor_row_r + 6'd1;
    end else if (app_ch != CH_RETURN) begin
      app_we = 1'b1;
      if (col_inc >= column_count_r) begin
        app_col = '0;
        app_row = cursor_row_r + 6'd1;
      end else begin
        app_col = col_inc[COL_W-1:0];
      end
    end
  end

  // Saturated register values for a configuration write.
  always_comb begin
    new_cols = column_count_r;
    new_rows = row_count_r;
    if (cfg_index == CFG_COLUMN_COUNT) begin
      if (cfg_data == 8'd0) begin
        new_cols = 8'd1;
      end else if (cfg_data > 8'(MAX_COLS)) begin
        new_cols = 8'(MAX_COLS);
      end else begin
        new_cols = cfg_data;
      end
    end else if (cfg_index == CFG_ROW_COUNT) begin
      if (cfg_data[5:0] == 6'd0) begin
        new_rows = 6'd1;
      end else if (cfg_data[5:0] > 6'(MAX_ROWS)) begin
        new_rows = 6'(MAX_ROWS);
      end else begin
        new_rows = cfg_data[5:0];
      end
    end
  end

  // Sequencer: clear pass, request intake, scroll copy, blank fill and result handoff.
  always_comb begin
    state_nxt        = state_r;
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    cursor_row_nxt   = cursor_row_r;
    cursor_col_nxt   = cursor_col_r;
    clr_addr_nxt     = clr_addr_r;
    scr_row_nxt      = scr_row_r;
    scr_col_nxt      = scr_col_r;
    cp_wr_nxt        = 1'b0;
    cp_addr_nxt      = cp_addr_r;
    ch_nxt           = ch_r;
    is_read_nxt      = is_read_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    mem_we           = 1'b0;
    mem_waddr        = cp_addr_r;
    mem_wdata        = rd_data_r;
    mem_re           = 1'b0;
    mem_raddr        = {scr_row_r, scr_col_r};

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    // A pending copy write lands in the cycle after its read.
    if (cp_wr_r) begin
      mem_we    = 1'b1;
      mem_waddr = cp_addr_r;
      mem_wdata = rd_data_r;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = BLANK_CELL;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          ch_nxt      = in_req.payload.char_code;
          is_read_nxt = (in_req.payload.req_type == REQ_READ);
          state_nxt   = S_DONE;
          if (in_req.payload.req_type == REQ_READ) begin
            mem_re    = 1'b1;
            mem_raddr = {in_req.payload.cell_row, in_req.payload.cell_col};
          end else if (in_req.payload.char_code != CH_NUL) begin
            if (scroll_need) begin
              scr_col_nxt = '0;
              scr_row_nxt = ROW_W'(1);
              state_nxt   = (row_count_r == 6'd1) ? S_BLANK : S_SCROLL;
            end else begin
              mem_we         = app_we;
              mem_waddr      = {cursor_row_r[ROW_W-1:0], cursor_col_r};
              mem_wdata      = {TEXT_ATTR, app_ch};
              cursor_row_nxt = app_row;
              cursor_col_nxt = app_col;
            end
          end
        end
      end
      S_SCROLL: begin
        mem_re      = 1'b1;
        mem_raddr   = {scr_row_r, scr_col_r};
        cp_wr_nxt   = 1'b1;
        cp_addr_nxt = {scr_row_r - ROW_W'(1), scr_col_r};
        if (col_last) begin
          scr_col_nxt = '0;
          if (row_last) begin
            state_nxt = S_BLANK;
          end else begin
            scr_row_nxt = scr_row_r + ROW_W'(1);
          end
        end else begin
          scr_col_nxt = scr_col_r + COL_W'(1);
        end
      end
      S_BLANK: begin
        if (!cp_wr_r) begin
          mem_we    = 1'b1;
          mem_waddr = {blank_row, scr_col_r};
          mem_wdata = BLANK_CELL;
          if (col_last) begin
            cursor_row_nxt = row_count_r - 6'd1;
            state_nxt      = S_APPLY;
          end else begin
            scr_col_nxt = scr_col_r + COL_W'(1);
          end
        end
      end
      S_APPLY: begin
        mem_we         = app_we;
        mem_waddr      = {cursor_row_r[ROW_W-1:0], cursor_col_r};
        mem_wdata      = {TEXT_ATTR, app_ch};
        cursor_row_nxt = app_row;
        cursor_col_nxt = app_col;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cell_data  = is_read_r ? rd_data_r : 16'd0;
          out_data_nxt.cursor_row = cursor_row_r;
          out_data_nxt.cursor_col = cursor_col_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // Configuration write with cursor clamping to the new screen size.
    if (cfg_we && (cfg_index == CFG_COLUMN_COUNT || cfg_index == CFG_ROW_COUNT)) begin
      column_count_nxt = new_cols;
      row_count_nxt    = new_rows;
      if (cursor_row_nxt > new_rows) begin
        cursor_row_nxt = new_rows;
      end
      if ({1'b0, cursor_col_nxt} >= new_cols) begin
        cursor_col_nxt = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      column_count_r <= RESET_COLS;
      row_count_r    <= RESET_ROWS;
      cursor_row_r   <= RESET_ROWS;
      cursor_col_r   <= '0;
      clr_addr_r     <= '0;
      cp_wr_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      cursor_row_r   <= cursor_row_nxt;
      cursor_col_r   <= cursor_col_nxt;
      clr_addr_r     <= clr_addr_nxt;
      cp_wr_r        <= cp_wr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scr_row_r  <= scr_row_nxt;
    scr_col_r  <= scr_col_nxt;
    cp_addr_r  <= cp_addr_nxt;
    ch_r       <= ch_nxt;
    is_read_r  <= is_read_nxt;
    out_data_r <= out_data_nxt;
  end

  // Cell memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Cell memory read port with registered data
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // The cursor never passes the scroll-pending row.
  a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_row_r <= row_count_r)
    else $error("cursor row beyond row count");

  // The cursor column stays inside the columns in use.
  a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_col_r} < column_count_r)
    else $error("cursor column beyond column count");

  // A copy write always follows a scroll read.
  a_copy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cp_wr_r |-> $past(state_r == S_SCROLL))
    else $error("copy write without scroll read");

  // A new result is only produced from the handoff state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside handoff");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("request accepted without leaving idle");

endmodule

// ===== verif/tb_text_console_scroll_writer_unit.sv =====
`timescale 1ns / 1ps

module tb_text_console_scroll_writer_unit import tcsw_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int REPORT_LIMIT   = 10;
  localparam int NUM_PHASES     = 40;

  logic clk;
  logic rst_n;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [7:0] cfg_data;

  tcsw_in_if  req_chan ();
  tcsw_out_if res_chan ();

  text_console_scroll_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_chan),
    .out_res   (res_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the console: screen contents, sizes in use and cursor.
  logic [15:0] screen_mirror [MAX_ROWS*MAX_COLS];
  int          cols_in_use;
  int          rows_in_use;
  int          cur_row;
  int          cur_col;

  in_req_t  outgoing_reqs [$];
  out_res_t console_replies [$];
  int       queued_reqs;
  int       accepted_reqs;
  int       fail_count;
  int       idle_cycles;
  int       req_gap_left;
  int       res_stall_left;
  bit       req_gaps_on;
  bit       res_stalls_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the mirror and returns the result the block should give.
  function automatic out_res_t console_reply(in_req_t r);
    out_res_t rep;
    rep.cell_data = '0;
    if (r.req_type == REQ_READ) begin
      rep.cell_data = screen_mirror[int'(r.cell_row) * MAX_COLS + int'(r.cell_col)];
    end else if (r.char_code != CH_NUL) begin
      // A pending scroll happens before anything else.
      if (cur_row >= rows_in_use) begin
        for (int rr = 1; rr < rows_in_use; rr++)
          for (int cc = 0; cc < cols_in_use; cc++)
            screen_mirror[(rr - 1) * MAX_COLS + cc] = screen_mirror[rr * MAX_COLS + cc];
        for (int cc = 0; cc < cols_in_use; cc++)
          screen_mirror[(rows_in_use - 1) * MAX_COLS + cc] = BLANK_CELL;
        cur_row = rows_in_use - 1;
      end
      if (r.char_code == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
      end else if (r.char_code != CH_RETURN) begin
        screen_mirror[cur_row * MAX_COLS + cur_col] = {TEXT_ATTR, r.char_code};
        cur_col++;
        if (cur_col >= cols_in_use) begin
          cur_col = 0;
          cur_row++;
        end
      end
    end
    rep.cursor_row = cur_row[5:0];
    rep.cursor_col = cur_col[6:0];
    return rep;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  task automatic push_req(in_req_t r);
    outgoing_reqs.push_back(r);
    queued_reqs++;
  endtask

  task automatic push_write(logic [7:0] ch);
    in_req_t r;
    r.req_type  = REQ_WRITE;
    r.char_code = ch;
    r.cell_row  = 5'($urandom_range(0, 31));
    r.cell_col  = 7'($urandom_range(0, 127));
    push_req(r);
  endtask

  task automatic push_read(logic [4:0] row, logic [6:0] col);
    in_req_t r;
    r.req_type  = REQ_READ;
    r.char_code = 8'($urandom_range(0, 255));
    r.cell_row  = row;
    r.cell_col  = col;
    push_req(r);
  endtask

  // Writes one register and mirrors the saturation and cursor clamping.
  task automatic write_reg(cfg_index_t idx, logic [7:0] val);
    int v;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_COLUMN_COUNT) begin
      v = int'(val);
      if (v < 1) v = 1;
      if (v > MAX_COLS) v = MAX_COLS;
      cols_in_use = v;
    end else begin
      v = int'(val[5:0]);
      if (v < 1) v = 1;
      if (v > MAX_ROWS) v = MAX_ROWS;
      rows_in_use = v;
    end
    if (cur_row > rows_in_use) cur_row = rows_in_use;
    if (cur_col >= cols_in_use) cur_col = 0;
  endtask

  task automatic write_sizes(logic [7:0] cols_val, logic [7:0] rows_val);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_COLUMN_COUNT, cols_val);
      write_reg(CFG_ROW_COUNT, rows_val);
    end else begin
      write_reg(CFG_ROW_COUNT, rows_val);
      write_reg(CFG_COLUMN_COUNT, cols_val);
    end
  endtask

  // Waits until every queued request has been taken and answered.
  task automatic drain();
    while (accepted_reqs != queued_reqs || console_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Random text with newlines, returns and NULs mixed in, plus reads biased to the area in use.
  task automatic run_random_phase(int n_items);
    in_req_t r;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      r.char_code = 8'($urandom_range(0, 255));
      r.cell_row  = 5'($urandom_range(0, 31));
      r.cell_col  = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        r.req_type = REQ_READ;
        if ($urandom_range(0, 3) != 0) begin
          r.cell_row = 5'($urandom_range(0, rows_in_use - 1));
          r.cell_col = 7'($urandom_range(0, cols_in_use - 1));
        end
      end else begin
        r.req_type = REQ_WRITE;
        if (pick < 38) r.char_code = CH_NEWLINE;
        else if (pick < 42) r.char_code = CH_RETURN;
        else if (pick < 45) r.char_code = CH_NUL;
      end
      push_req(r);
    end
  endtask

  // Request driver: presents the next queued request, with random gaps after each one when gaps are on.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_chan.valid <= 1'b0;
      req_gap_left   <= 0;
    end else if (!req_chan.valid || req_chan.ready) begin
      if (req_gap_left > 0) begin
        req_chan.valid <= 1'b0;
        req_gap_left   <= req_gap_left - 1;
      end else if (outgoing_reqs.size() > 0) begin
        req_chan.payload <= outgoing_reqs.pop_front();
        req_chan.valid   <= 1'b1;
        req_gap_left     <= req_gaps_on ? idle_len() : 0;
      end else begin
        req_chan.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: random stalls independent of the block's state.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
      res_stall_left <= 0;
    end else if (res_stall_left > 0) begin
      res_chan.ready <= 1'b0;
      res_stall_left <= res_stall_left - 1;
    end else begin
      res_chan.ready <= 1'b1;
      if (res_stalls_on && $urandom_range(0, 3) == 0) res_stall_left <= idle_len();
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin : result_check
    out_res_t want;
    out_res_t got;
    if (rst_n) begin
      if (res_chan.valid && res_chan.ready) begin
        got = res_chan.payload;
        if (console_replies.size() == 0) begin
          note_failure($sformatf("unexpected result %h", got));
        end else begin
          want = console_replies.pop_front();
          if (got.cell_data !== want.cell_data || got.cursor_row !== want.cursor_row ||
              got.cursor_col !== want.cursor_col)
            note_failure($sformatf(
              "cell_data exp %h got %h, cursor_row exp %0d got %0d, cursor_col exp %0d got %0d",
              want.cell_data, got.cell_data, want.cursor_row, got.cursor_row,
              want.cursor_col, got.cursor_col));
        end
      end
      if (req_chan.valid && req_chan.ready) begin
        console_replies.push_back(console_reply(req_chan.payload));
        accepted_reqs++;
      end
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk) begin
    if ((req_chan.valid && req_chan.ready) || (res_chan.valid && res_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int cols_val;
    int rows_val;
    int n_items;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_COLUMN_COUNT;
    cfg_data         <= '0;
    fail_count       = 0;
    queued_reqs      = 0;
    accepted_reqs    = 0;
    req_gaps_on      = 1'b1;
    res_stalls_on    = 1'b1;

    // Mirror starts in the reset state: blank screen, scroll pending.
    for (int i = 0; i < MAX_ROWS * MAX_COLS; i++) screen_mirror[i] = BLANK_CELL;
    cols_in_use = int'(RESET_COLS);
    rows_in_use = int'(RESET_ROWS);
    cur_row     = int'(RESET_ROWS);
    cur_col     = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset sizes, NUL, return with pending scroll, high bytes, newline.
    push_read(5'd0, 7'd0);
    push_write(CH_NUL);
    push_write(CH_RETURN);
    push_write(8'h48);
    push_write(8'hFF);
    push_write(8'h80);
    push_write(8'h7F);
    push_write(CH_NEWLINE);
    push_write(8'h01);
    push_read(5'd23, 7'd0);
    push_read(5'd23, 7'd1);
    push_read(5'd23, 7'd2);
    push_read(5'd24, 7'd0);
    push_read(5'd31, 7'd127);
    push_write(CH_NUL);
    drain();

    // Directed: sizes below range saturate to one by one, cursor clamps.
    write_sizes(8'd0, 8'd0);
    push_write(8'hAA);
    push_read(5'd0, 7'd0);
    push_write(8'h55);
    push_write(CH_NEWLINE);
    push_read(5'd0, 7'd0);
    push_read(5'd0, 7'd1);
    drain();

    // Directed: sizes above range saturate to the maximum; return without a scroll.
    write_sizes(8'hFF, 8'hFF);
    push_write(CH_RETURN);
    push_write(8'h41);
    push_read(5'd1, 7'd0);
    drain();

    // Random phases over a spread of screen sizes.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          cols_val = 128;
          rows_val = 32;
        end
        1: begin
          cols_val = 1;
          rows_val = 1;
        end
        2: begin
          cols_val = 128;
          rows_val = 1;
        end
        3: begin
          cols_val = 1;
          rows_val = 32;
        end
        4: begin
          cols_val = 3;
          rows_val = 8'hC5;
        end
        5: begin
          cols_val = int'(RESET_COLS);
          rows_val = int'(RESET_ROWS);
        end
        default: begin
          cols_val = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(0, 255);
          rows_val = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(0, 255);
        end
      endcase
      write_sizes(cols_val[7:0], rows_val[7:0]);
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      res_stalls_on = ($urandom_range(0, 3) != 0);
      n_items = (cols_in_use * rows_in_use > 1024) ? 40 : 50;
      run_random_phase(n_items);
      drain();
    end

    repeat (20) @(posedge clk);
    if (console_replies.size() != 0)
      note_failure($sformatf("%0d results never arrived", console_replies.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
